/* rtl/esp_pkg.sv */
`timescale 1ns / 1ps

package esp_pkg;

    localparam int COUNT_W    = 16;
    localparam int ELAPSED_W  = 24;
    localparam int SPEED_W    = 32;
    localparam int PULSES_W   = 16;
    localparam int COEFF_W    = 9;
    localparam int CFG_DATA_W = 16;

    // 60e6 us per minute; the extra factor of 256 for Q8 is a shift.
    localparam int          SCALE_W   = 26;
    localparam logic [SCALE_W-1:0] RPM_SCALE = 26'd60000000;
    localparam int          FRAC_BITS = 8;

    // Product widths of the two serial multipliers and of the divider.
    localparam int DEN_W   = ELAPSED_W + PULSES_W;    // 40
    localparam int NUM0_W  = SCALE_W + COUNT_W;       // 42
    localparam int NUM0_USED_W = 41;                  // 32768 * 60e6 < 2^41
    localparam int NUM_W   = NUM0_USED_W + FRAC_BITS; // 49

    // Blend accumulator: nw * 256 + c * (old - nw).
    localparam int ACC_W      = 43;
    localparam int DIFF_W     = SPEED_W + 1;
    localparam int BLEND_CNT_W = 4;

    localparam logic [PULSES_W-1:0] PULSES_RESET = 16'd1;
    localparam logic [COEFF_W-1:0]  COEFF_RESET  = 9'd192;
    localparam logic [COEFF_W-1:0]  COEFF_ONE    = 9'd256;

    localparam logic [SPEED_W-1:0] SPEED_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [SPEED_W-1:0] SPEED_NEG_MAG = 32'h8000_0000;

    typedef enum logic [0:0] {
        REG_PULSES_PER_REV = 1'b0,
        REG_FILTER_COEFF   = 1'b1
    } esp_reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_BLEND,
        ST_OUT
    } esp_state_t;

    typedef struct packed {
        logic [COUNT_W-1:0]   count_value;
        logic [ELAPSED_W-1:0] elapsed_us;
    } esp_sample_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed_q8;
        logic [COUNT_W-1:0]        position;
        logic                      speed_updated;
    } esp_result_t;

    typedef struct packed {
        esp_reg_idx_t            index;
        logic [CFG_DATA_W-1:0]   data;
    } esp_cfg_t;

endpackage

/* rtl/esp_stream_if.sv */
`timescale 1ns / 1ps

interface esp_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/esp_serial_mul.sv */
`timescale 1ns / 1ps

module esp_serial_mul #(
    parameter int A_W = 8,
    parameter int B_W = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic [A_W+B_W-1:0] product,
    output logic               done
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic [P_W-1:0]   acc_reg;
    logic [P_W-1:0]   a_sh_reg;
    logic [B_W-1:0]   b_sh_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             last_step;

    assign last_step = busy_reg && (cnt_reg == CNT_W'(B_W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // One multiplier bit per cycle, least significant first.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg  <= '0;
            a_sh_reg <= {{B_W{1'b0}}, a};
            b_sh_reg <= b;
        end
        else if (busy_reg)
        begin
            if (b_sh_reg[0])
            begin
                acc_reg <= acc_reg + a_sh_reg;
            end
            a_sh_reg <= a_sh_reg << 1;
            b_sh_reg <= b_sh_reg >> 1;
        end
    end

    assign product = acc_reg;
    assign done    = done_reg;

endmodule

/* rtl/esp_serial_div.sv */
`timescale 1ns / 1ps

module esp_serial_div #(
    parameter int N_W = 16,
    parameter int D_W = 16,
    parameter int Q_W = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic [Q_W-1:0] quotient,
    output logic           overflow,
    output logic           done
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [D_W-1:0]   rem_reg;
    logic [D_W-1:0]   rem_next;
    logic [N_W-1:0]   num_sh_reg;
    logic [D_W-1:0]   div_reg;
    logic [Q_W-1:0]   quo_reg;
    logic             ovf_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             last_step;
    logic [D_W:0]     trial;
    logic [D_W:0]     trial_sub;
    logic             fits;

    assign last_step = busy_reg && (cnt_reg == CNT_W'(N_W - 1));

    // Restoring division, one quotient bit per cycle.
    always_comb
    begin
        trial     = {rem_reg, num_sh_reg[N_W-1]};
        trial_sub = trial - {1'b0, div_reg};
        fits      = (trial >= {1'b0, div_reg});
        rem_next  = fits ? trial_sub[D_W-1:0] : trial[D_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Quotient bits that fall off the top of the register mark an overflow.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg    <= '0;
            num_sh_reg <= dividend;
            div_reg    <= divisor;
            quo_reg    <= '0;
            ovf_reg    <= 1'b0;
        end
        else if (busy_reg)
        begin
            rem_reg    <= rem_next;
            num_sh_reg <= num_sh_reg << 1;
            quo_reg    <= {quo_reg[Q_W-2:0], fits};
            ovf_reg    <= ovf_reg | quo_reg[Q_W-1];
        end
    end

    assign quotient = quo_reg;
    assign overflow = ovf_reg;
    assign done     = done_reg;

endmodule

/* rtl/encoder_speed_estimator.sv */
`timescale 1ns / 1ps

// Encoder speed estimator.
// The sample channel takes one item per encoder reading: the 16-bit count and
// the microseconds since the previous reading. The result channel returns one
// item per sample: the filtered speed in Q8 rpm, the stored count and a flag
// that tells whether the speed was updated. The cfg channel writes
// pulses_per_rev (index 0) and filter_coeff (index 1); it is always ready and
// should only be used while no sample is in flight.
// A sample that updates the speed goes through a bit-serial multiply, a
// bit-serial divide and a serial blend before its result is loaded; no new
// sample is taken until then, and the next one can be taken in the cycle
// after the load. The divide is the longest step.
// The first sample after reset and samples with zero elapsed time skip the
// multiply, divide and blend and go straight to the output stage.
// The result sits in an output register; when the receiver stalls, the block
// still accepts one more sample and finishes it, then waits with that result
// until the register frees up.
// Reset clears the stored count, the filtered speed and the primed flag, and
// sets pulses_per_rev to 1 and filter_coeff to 192.
module encoder_speed_estimator (
    input logic         clk,
    input logic         rst_n,
    esp_stream_if.sink   sample,
    esp_stream_if.source result,
    esp_stream_if.sink   cfg
);
    import esp_pkg::*;

    esp_state_t state_reg;
    esp_state_t state_next;

    logic [PULSES_W-1:0] pulses_reg;
    logic [COEFF_W-1:0]  coeff_reg;

    logic [COUNT_W-1:0]        last_count_reg;
    logic                      primed_reg;
    logic signed [SPEED_W-1:0] speed_reg;
    logic                      neg_reg;
    logic                      upd_reg;

    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   dsh_reg;
    logic [COEFF_W-1:0]        csh_reg;
    logic [BLEND_CNT_W-1:0]    bcnt_reg;

    esp_result_t result_reg;
    logic        result_valid_reg;

    logic                sample_acc;
    logic                go;
    logic                mul_start;
    logic                div_start;
    logic                load;
    logic                blend_last;
    logic [COUNT_W-1:0]  count_diff;
    logic [COUNT_W-1:0]  delta_mag;
    logic [PULSES_W-1:0] ppr_eff;
    logic [COEFF_W-1:0]  coeff_eff;

    logic [DEN_W-1:0]  den_prod;
    logic [NUM0_W-1:0] num_prod;
    logic              den_done;
    logic              num_done;
    logic [NUM_W-1:0]  dividend;
    logic [SPEED_W-1:0] quotient;
    logic              quo_ovf;
    logic              div_done;

    logic [SPEED_W-1:0]        inst_mag;
    logic signed [SPEED_W-1:0] inst_speed;
    logic signed [DIFF_W-1:0]  speed_diff;
    logic signed [ACC_W-FRAC_BITS-1:0] blend_q;
    logic signed [SPEED_W-1:0] speed_new;

    // Configuration registers.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulses_reg <= PULSES_RESET;
            coeff_reg  <= COEFF_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.payload.index)
                REG_PULSES_PER_REV: pulses_reg <= cfg.payload.data;
                REG_FILTER_COEFF:   coeff_reg  <= cfg.payload.data[COEFF_W-1:0];
                default:            ;
            endcase
        end
    end

    assign ppr_eff   = (pulses_reg == '0) ? PULSES_W'(1) : pulses_reg;
    assign coeff_eff = (coeff_reg > COEFF_ONE) ? COEFF_ONE : coeff_reg;

    // Input side.
    assign sample.ready = (state_reg == ST_IDLE);
    assign sample_acc   = sample.valid && sample.ready;
    assign count_diff   = sample.payload.count_value - last_count_reg;
    assign delta_mag    = count_diff[COUNT_W-1] ? (~count_diff + COUNT_W'(1)) : count_diff;
    assign go           = sample_acc && primed_reg && (sample.payload.elapsed_us != '0);

    esp_serial_mul #(
        .A_W (ELAPSED_W),
        .B_W (PULSES_W)
    ) u_den_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (sample.payload.elapsed_us),
        .b       (ppr_eff),
        .product (den_prod),
        .done    (den_done)
    );

    esp_serial_mul #(
        .A_W (SCALE_W),
        .B_W (COUNT_W)
    ) u_num_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (RPM_SCALE),
        .b       (delta_mag),
        .product (num_prod),
        .done    (num_done)
    );

    assign dividend = {num_prod[NUM0_USED_W-1:0], {FRAC_BITS{1'b0}}};

    esp_serial_div #(
        .N_W (NUM_W),
        .D_W (DEN_W),
        .Q_W (SPEED_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (den_prod),
        .quotient (quotient),
        .overflow (quo_ovf),
        .done     (div_done)
    );

    // Instantaneous speed, saturated to the signed 32-bit range.
    always_comb
    begin
        if (neg_reg)
        begin
            inst_mag   = (quo_ovf || (quotient > SPEED_NEG_MAG)) ? SPEED_NEG_MAG : quotient;
            inst_speed = signed'(~inst_mag + SPEED_W'(1));
        end
        else
        begin
            inst_mag   = (quo_ovf || quotient[SPEED_W-1]) ? SPEED_POS_MAX : quotient;
            inst_speed = signed'(inst_mag);
        end
        speed_diff = signed'({speed_reg[SPEED_W-1], speed_reg})
                   - signed'({inst_speed[SPEED_W-1], inst_speed});
    end

    // Divide the blend sum by 256, truncating toward zero. A convex blend of
    // two 32-bit values always fits in 32 bits.
    always_comb
    begin
        blend_q = acc_reg[ACC_W-1:FRAC_BITS];
        if (acc_reg[ACC_W-1] && (acc_reg[FRAC_BITS-1:0] != '0))
        begin
            blend_q = blend_q + (ACC_W-FRAC_BITS)'(1);
        end
        speed_new = upd_reg ? blend_q[SPEED_W-1:0] : speed_reg;
    end

    assign blend_last = (bcnt_reg == BLEND_CNT_W'(COEFF_W - 1));

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        load       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (go)
                begin
                    mul_start  = 1'b1;
                    state_next = ST_MUL;
                end
                else if (sample_acc)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_MUL:
            begin
                if (den_done && num_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_BLEND;
                end
            end
            ST_BLEND:
            begin
                if (blend_last)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!result_valid_reg || result.ready)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Block state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_count_reg <= '0;
            primed_reg     <= 1'b0;
            speed_reg      <= '0;
            upd_reg        <= 1'b0;
        end
        else
        begin
            if (sample_acc)
            begin
                last_count_reg <= sample.payload.count_value;
                primed_reg     <= 1'b1;
                upd_reg        <= 1'b0;
            end
            else if (state_reg == ST_BLEND && blend_last)
            begin
                upd_reg <= 1'b1;
            end
            if (load)
            begin
                speed_reg <= speed_new;
            end
        end
    end

    // Blend datapath: acc = new * 256 + c * (old - new), one bit of c a cycle.
    always_ff @(posedge clk)
    begin
        if (sample_acc)
        begin
            neg_reg <= count_diff[COUNT_W-1];
        end
        if (state_reg == ST_DIV && div_done)
        begin
            acc_reg  <= signed'({{(ACC_W-SPEED_W-FRAC_BITS){inst_speed[SPEED_W-1]}},
                                inst_speed, {FRAC_BITS{1'b0}}});
            dsh_reg  <= signed'({{(ACC_W-DIFF_W){speed_diff[DIFF_W-1]}}, speed_diff});
            csh_reg  <= coeff_eff;
            bcnt_reg <= '0;
        end
        else if (state_reg == ST_BLEND)
        begin
            if (csh_reg[0])
            begin
                acc_reg <= acc_reg + dsh_reg;
            end
            dsh_reg  <= dsh_reg <<< 1;
            csh_reg  <= csh_reg >> 1;
            bcnt_reg <= bcnt_reg + BLEND_CNT_W'(1);
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg.speed_q8      <= speed_new;
            result_reg.position      <= last_count_reg;
            result_reg.speed_updated <= upd_reg;
        end
    end

    assign result.valid   = result_valid_reg;
    assign result.payload = result_reg;

endmodule

/* rtl/esp_checker.sv */
`timescale 1ns / 1ps

module esp_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 sample_valid,
    input logic                 sample_ready,
    input logic [15:0]          count_value,
    input logic                 result_valid,
    input logic                 result_ready,
    input esp_pkg::esp_result_t result_payload
);
    import esp_pkg::*;

    logic [COUNT_W-1:0] last_in_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_in_count_reg <= '0;
        end
        else if (sample_valid && sample_ready)
        begin
            last_in_count_reg <= count_value;
        end
    end

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result item dropped while stalled");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result_payload))
        else $error("result item changed while stalled");

    // Only one sample is in flight, so a fresh result belongs to the last sample.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("sample taken while another is in flight");

    a_position: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> result_payload.position == last_in_count_reg)
        else $error("result position does not match the last sample");

endmodule

bind encoder_speed_estimator esp_checker u_esp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .sample_valid   (sample.valid),
    .sample_ready   (sample.ready),
    .count_value    (sample.payload.count_value),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_payload (result.payload)
);

/* tb/sv/encoder_speed_estimator_tb.sv */
`timescale 1ns / 1ps

module encoder_speed_estimator_tb;
    import esp_pkg::*;

    localparam longint SPEED_MAX   = 64'sd2147483647;
    localparam longint SPEED_MIN   = -64'sd2147483648;
    localparam int     RAND_PHASES = 8;
    localparam int     PHASE_ITEMS = 200;

    // One row of the directed table: either a register setting or a sample.
    typedef struct {
        bit        regs;
        bit [15:0] ppr;
        bit [8:0]  coeff;
        bit [15:0] count;
        bit [23:0] elapsed;
        bit        known;
        bit [31:0] want_speed;
        bit        want_upd;
    } bench_row_t;

    logic clk = 1'b0;
    logic rst_n;

    esp_stream_if #(.payload_t(esp_sample_t)) sample_if ();
    esp_stream_if #(.payload_t(esp_result_t)) result_if ();
    esp_stream_if #(.payload_t(esp_cfg_t))    cfg_if ();

    encoder_speed_estimator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    always #4 clk = ~clk;

    // Shadow of the block's registers and state.
    logic [15:0] cfg_pulses;
    logic [8:0]  cfg_coeff;
    logic [15:0] last_position;
    int          filtered_q8;
    bit          primed_seen;

    esp_result_t pending_speeds [$];

    bit idle_on = 1'b1;
    bit rx_hold = 1'b0;
    int samples_fed = 0;
    int results_seen = 0;
    int updates_seen = 0;
    int speed_errors = 0;
    int settings_used = 0;

    bench_row_t dir_rows [24] = '{
        '{1'b0, 16'd0,     9'd0,   16'h0064, 24'd1000,     1'b1, 32'd0,         1'b0},
        '{1'b0, 16'd0,     9'd0,   16'h0064, 24'd0,        1'b1, 32'd0,         1'b0},
        '{1'b0, 16'd0,     9'd0,   16'h0064, 24'd1000,     1'b1, 32'd0,         1'b1},
        '{1'b0, 16'd0,     9'd0,   16'h0065, 24'd1000,     1'b0, 32'd0,         1'b0},
        '{1'b0, 16'd0,     9'd0,   16'h0063, 24'd500,      1'b0, 32'd0,         1'b0},
        '{1'b1, 16'd1,     9'd0,   16'h0000, 24'd0,        1'b0, 32'd0,         1'b0},
        '{1'b0, 16'd0,     9'd0,   16'h8062, 24'd1,        1'b1, 32'h7FFF_FFFF, 1'b1},
        '{1'b0, 16'd0,     9'd0,   16'h0062, 24'd1,        1'b1, 32'h8000_0000, 1'b1},
        '{1'b0, 16'd0,     9'd0,   16'hFFFF, 24'hFF_FFFF,  1'b0, 32'd0,         1'b0},
        '{1'b0, 16'd0,     9'd0,   16'h0000, 24'hFF_FFFF,  1'b0, 32'd0,         1'b0},
        '{1'b1, 16'd0,     9'd256, 16'h0000, 24'd0,        1'b0, 32'd0,         1'b0},
        '{1'b0, 16'd0,     9'd0,   16'h0010, 24'd1,        1'b0, 32'd0,         1'b0},
        '{1'b1, 16'hFFFF,  9'h1FF, 16'h0000, 24'd0,        1'b0, 32'd0,         1'b0},
        '{1'b0, 16'd0,     9'd0,   16'h1234, 24'd12345,    1'b0, 32'd0,         1'b0},
        '{1'b1, 16'hFFFF,  9'd128, 16'h0000, 24'd0,        1'b0, 32'd0,         1'b0},
        '{1'b0, 16'd0,     9'd0,   16'h1240, 24'hFF_FFFF,  1'b0, 32'd0,         1'b0},
        '{1'b0, 16'd0,     9'd0,   16'hFFFF, 24'hFF_FFFF,  1'b0, 32'd0,         1'b0},
        '{1'b0, 16'd0,     9'd0,   16'hFFFF, 24'd0,        1'b0, 32'd0,         1'b0},
        '{1'b1, 16'd2048,  9'd1,   16'h0000, 24'd0,        1'b0, 32'd0,         1'b0},
        '{1'b0, 16'd0,     9'd0,   16'h0800, 24'd1000,     1'b0, 32'd0,         1'b0},
        '{1'b0, 16'd0,     9'd0,   16'h0000, 24'd1,        1'b0, 32'd0,         1'b0},
        '{1'b0, 16'd0,     9'd0,   16'h7FFF, 24'h80_0000,  1'b0, 32'd0,         1'b0},
        '{1'b0, 16'd0,     9'd0,   16'h5555, 24'h55_5555,  1'b0, 32'd0,         1'b0},
        '{1'b0, 16'd0,     9'd0,   16'hAAAA, 24'hAA_AAAA,  1'b0, 32'd0,         1'b0}
    };

    // Advances the shadow state by one sample and returns the result it causes.
    function automatic esp_result_t next_speed_result(input esp_sample_t smp);
        logic [15:0]     diff;
        int              delta;
        longint unsigned mag;
        longint unsigned ppr_eff;
        longint unsigned span;
        longint unsigned quo;
        longint          inst;
        longint          weight;
        longint          blend;
        esp_result_t     res;

        diff  = smp.count_value - last_position;
        delta = diff[15] ? int'(diff) - 65536 : int'(diff);
        last_position = smp.count_value;
        res.speed_updated = 1'b0;

        if (smp.elapsed_us != '0 && primed_seen)
        begin
            mag     = (delta < 0) ? -delta : delta;
            ppr_eff = (cfg_pulses == '0) ? 64'd1 : 64'(cfg_pulses);
            span    = 64'(smp.elapsed_us);
            quo     = (mag * 64'd60000000 * 64'd256) / (ppr_eff * span);
            if (delta < 0)
            begin
                if (quo > 64'd2147483648)
                    quo = 64'd2147483648;
                inst = -longint'(quo);
            end
            else
            begin
                if (quo > 64'd2147483647)
                    quo = 64'd2147483647;
                inst = longint'(quo);
            end
            weight = (cfg_coeff > 9'd256) ? 64'sd256 : longint'(cfg_coeff);
            blend  = (weight * longint'(filtered_q8) + (64'sd256 - weight) * inst) / 64'sd256;
            if (blend > SPEED_MAX)
                blend = SPEED_MAX;
            if (blend < SPEED_MIN)
                blend = SPEED_MIN;
            filtered_q8 = int'(blend);
            res.speed_updated = 1'b1;
        end
        primed_seen = 1'b1;

        res.speed_q8 = filtered_q8;
        res.position = smp.count_value;
        return res;
    endfunction

    // Both registers are written back to back once the block has drained.
    task automatic load_settings(input logic [15:0] ppr, input logic [8:0] coeff);
        sample_if.valid <= 1'b0;
        while (pending_speeds.size() != 0)
            @(posedge clk);
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= '{index: REG_PULSES_PER_REV, data: ppr};
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_pulses = ppr;
        cfg_if.payload <= '{index: REG_FILTER_COEFF, data: 16'(coeff)};
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_coeff = coeff;
        cfg_if.valid <= 1'b0;
        settings_used++;
    endtask

    // Valid is only lowered for a real gap, so back-to-back items keep it high.
    task automatic feed_sample(input logic [15:0] cnt, input logic [23:0] span,
                               input bit known, input esp_result_t want);
        int          gap;
        esp_result_t pred;

        gap = idle_on ? $urandom_range(0, 19) : 0;
        if (gap != 0)
        begin
            sample_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_if.valid   <= 1'b1;
        sample_if.payload <= '{count_value: cnt, elapsed_us: span};
        do
            @(posedge clk);
        while (!sample_if.ready);
        pred = next_speed_result('{count_value: cnt, elapsed_us: span});
        pending_speeds.push_back(known ? want : pred);
        samples_fed++;
    endtask

    task automatic check_result(input esp_result_t got);
        esp_result_t want;

        results_seen++;
        if (got.speed_updated)
            updates_seen++;
        if (pending_speeds.size() == 0)
        begin
            $error("result item with no sample pending: speed_q8 %0d position %0d",
                   got.speed_q8, got.position);
            speed_errors++;
        end
        else
        begin
            want = pending_speeds.pop_front();
            if (got.speed_q8 !== want.speed_q8)
            begin
                $error("speed_q8: expected %0d, got %0d", want.speed_q8, got.speed_q8);
                speed_errors++;
            end
            if (got.position !== want.position)
            begin
                $error("position: expected %0d, got %0d", want.position, got.position);
                speed_errors++;
            end
            if (got.speed_updated !== want.speed_updated)
            begin
                $error("speed_updated: expected %0d, got %0d",
                       want.speed_updated, got.speed_updated);
                speed_errors++;
            end
        end
    endtask

    // Result side: checks every accepted item and draws a stall after each one.
    initial
    begin
        int stall;

        result_if.ready = 1'b0;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                result_if.ready <= 1'b0;
            else
            begin
                if (result_if.valid && result_if.ready)
                begin
                    check_result(result_if.payload);
                    stall = idle_on ? $urandom_range(0, 19) : 0;
                end
                else if (stall != 0)
                    stall--;
                result_if.ready <= !rx_hold && stall == 0;
            end
        end
    end

    // Long hold-off on the result side so the block backs up into the sample input.
    initial
    begin
        wait (samples_fed >= 600);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (1500) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("encoder_speed_estimator verification failed");
        $finish;
    end

    initial
    begin
        esp_result_t want;
        logic [15:0] cnt;
        logic [23:0] span;
        int unsigned stride;
        int unsigned pick;

        sample_if.valid   = 1'b0;
        sample_if.payload = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.payload    = '0;
        rst_n             = 1'b0;

        cfg_pulses    = PULSES_RESET;
        cfg_coeff     = COEFF_RESET;
        last_position = '0;
        filtered_q8   = 0;
        primed_seen   = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].regs)
                load_settings(dir_rows[i].ppr, dir_rows[i].coeff);
            else
            begin
                want.speed_q8      = dir_rows[i].want_speed;
                want.position      = dir_rows[i].count;
                want.speed_updated = dir_rows[i].want_upd;
                feed_sample(dir_rows[i].count, dir_rows[i].elapsed, dir_rows[i].known, want);
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0: load_settings(PULSES_RESET, COEFF_RESET);
                1: load_settings(16'hFFFF, 9'd0);
                2: load_settings(16'd0, COEFF_ONE);
                3: load_settings(16'd360, 9'h1FF);
                default:
                    if ($urandom_range(0, 3) == 0)
                        load_settings(16'($urandom), 9'($urandom_range(0, 511)));
                    else
                        load_settings(16'($urandom_range(1, 4096)), 9'($urandom_range(0, 511)));
            endcase
            // Every third phase runs with no idle cycles on either side.
            idle_on = (ph % 3 != 2);

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 8)
                begin
                    // Plausible encoder motion: a bounded step since the last reading.
                    stride = $urandom_range(0, (pick < 4) ? 200 : 4000);
                    cnt    = $urandom_range(0, 1) ? last_position + 16'(stride)
                                                  : last_position - 16'(stride);
                    span   = 24'($urandom_range(100, 5000));
                end
                else if (pick == 8)
                begin
                    cnt  = last_position + 16'($urandom_range(0, 50));
                    span = '0;
                end
                else
                begin
                    cnt  = 16'($urandom);
                    span = 24'($urandom);
                end
                feed_sample(cnt, span, 1'b0, '0);
            end
        end

        sample_if.valid <= 1'b0;
        while (pending_speeds.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Fed %0d samples (%0d-row directed table first) under %0d register settings.",
                 samples_fed, $size(dir_rows), settings_used);
        $display("Checked %0d results, %0d of them speed updates, %0d mismatches.",
                 results_seen, updates_seen, speed_errors);
        if (speed_errors == 0)
            $display("encoder_speed_estimator verification clean");
        else
            $display("encoder_speed_estimator verification failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/esp_pkg.sv
rtl/esp_stream_if.sv
rtl/esp_serial_mul.sv
rtl/esp_serial_div.sv
rtl/encoder_speed_estimator.sv
rtl/esp_checker.sv
tb/sv/encoder_speed_estimator_tb.sv
